// ----- hw/rtl/emfo_pkg.sv -----
// Shared types, constants and arithmetic helpers of the back-EMF speed and angle observer.
package emfo_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_RESISTANCE  = 3'd0;
   localparam logic [2:0] REG_D_IND       = 3'd1;
   localparam logic [2:0] REG_Q_IND       = 3'd2;
   localparam logic [2:0] REG_FLUX        = 3'd3;
   localparam logic [2:0] REG_SAMPLE      = 3'd4;
   localparam logic [2:0] REG_LAMBDA      = 3'd5;
   localparam logic [2:0] REG_BASE_BW     = 3'd6;
   localparam logic [2:0] REG_BW_SLOPE    = 3'd7;

   localparam logic [31:0] RST_SAMPLE  = 32'd429497;
   localparam logic [30:0] RST_LAMBDA  = 31'd131072;
   localparam logic [30:0] RST_BASE_BW = 31'd25735867;
   localparam logic [30:0] RST_SLOPE   = 31'd262144;

   // Angle wrap limits in Q16.16.
   localparam logic [31:0] ANG_PI     = 32'd205887;
   localparam logic [31:0] ANG_TWO_PI = 32'd411775;

   // Reciprocal of 2*pi scaled by 2^50; the product with a 32-bit magnitude
   // gives the wrap count in bits 63:50, low by at most one.
   localparam logic [31:0] WRAP_RECIP = 32'((64'd1 << 50) / 64'(ANG_TWO_PI));

   localparam int DIV_DVD_W = 48;
   localparam int DIV_DSR_W = 32;
   localparam int DIV_CNT_W = 6;

   typedef struct packed {
      logic [30:0] resistance;
      logic [30:0] d_inductance;
      logic [30:0] q_inductance;
      logic [30:0] flux_linkage;
      logic [31:0] sample_period;
      logic [30:0] lambda_gain;
      logic [30:0] base_bandwidth;
      logic [30:0] bandwidth_slope;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_DVD_W-1:0] dividend;
      logic [DIV_DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic [DIV_DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RID,
      ST_WLQ,
      ST_RIQ,
      ST_P3,
      ST_ED,
      ST_P5,
      ST_P8,
      ST_EQ,
      ST_NUM,
      ST_BW,
      ST_ANG,
      ST_XPR,
      ST_QE,
      ST_RM,
      ST_WQ,
      ST_ML,
      ST_MH,
      ST_SPD,
      ST_WM
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) r = 32'sh7fffffff;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   // Q16.16 product: round half toward plus infinity, then saturate.
   function automatic logic signed [31:0] qround(input logic signed [65:0] p);
      logic signed [65:0] t;
      t = (p + 66'sd32768) >>> 16;
      return sat32(t[63:0]);
   endfunction

endpackage

// ----- hw/rtl/emfo_if.sv -----
// Valid/ready channel interfaces for observer input and result items.
interface emfo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] d_voltage;
   logic signed [31:0] q_voltage;
   logic signed [31:0] d_current;
   logic signed [31:0] q_current;
   modport source (output valid, d_voltage, q_voltage, d_current, q_current, input ready);
   modport sink (input valid, d_voltage, q_voltage, d_current, q_current, output ready);
endinterface

interface emfo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] speed_estimate;
   logic               divide_fault;
   modport source (output valid, angle_estimate, speed_estimate, divide_fault, input ready);
   modport sink (input valid, angle_estimate, speed_estimate, divide_fault, output ready);
endinterface

// ----- hw/rtl/pmsm_emf_speed_angle_observer.sv -----
// Top level of the PMSM back-EMF speed and angle observer.
//
// Once per control period an item with the commanded dq voltages and
// currents enters on the req channel. The block forms the d and q back-EMF
// from its stored speed, advances and wraps the electrical angle, and moves
// the speed toward the flux-normalized EMF estimate. Each item yields one
// result item on the rsp channel with the new angle, the new speed and a
// flag that reports a zero flux divisor.
// All products and the quotient go through one 33 by 33 bit multiplier and one
// restoring divider under a small sequencer. Fifteen multiplier steps run in
// order, the angle wrap among them as a reciprocal product; the angle advance
// and wrap overlap the divide of the speed quotient, and four more steps finish
// the speed. A new item is not taken before the sequencer is through with the
// last one; req.ready is high only while the sequencer is idle.
// A finished result sits in an output register; the next item is accepted
// while it waits, but that item's result is held back until the first one
// is taken, so a stalled receiver eventually stalls the sender.
// Synchronous reset clears angle and speed to zero, empties the output
// register and loads the configuration registers with their defaults.
// The csr port writes registers at word addresses, one register each.
module pmsm_emf_speed_angle_observer (
   input  logic                            clock,
   input  logic                            reset,
   emfo_req_if.sink                        req,
   emfo_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [emfo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [emfo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [emfo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   emfo_pkg::cfg_type cfg;

   // Register file; the user must change configuration only while no item is in flight, the block does not enforce it.
   emfo_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready),
      .cfg(cfg)
   );

   // Sequencer with the shared multiplier and divider.
   emfo_core u_core (
      .clock(clock), .reset(reset), .cfg(cfg), .req(req), .rsp(rsp)
   );
endmodule

// ----- hw/rtl/emfo_csr.sv -----
// APB-style configuration register file of the observer.
module emfo_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [emfo_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [emfo_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [emfo_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output emfo_pkg::cfg_type                 cfg
);
   emfo_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            emfo_pkg::REG_RESISTANCE: cfg_in.resistance = csr_pwdata[30:0];
            emfo_pkg::REG_D_IND:      cfg_in.d_inductance = csr_pwdata[30:0];
            emfo_pkg::REG_Q_IND:      cfg_in.q_inductance = csr_pwdata[30:0];
            emfo_pkg::REG_FLUX:       cfg_in.flux_linkage = csr_pwdata[30:0];
            emfo_pkg::REG_SAMPLE:     cfg_in.sample_period = csr_pwdata;
            emfo_pkg::REG_LAMBDA:     cfg_in.lambda_gain = csr_pwdata[30:0];
            emfo_pkg::REG_BASE_BW:    cfg_in.base_bandwidth = csr_pwdata[30:0];
            emfo_pkg::REG_BW_SLOPE:   cfg_in.bandwidth_slope = csr_pwdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         emfo_pkg::REG_RESISTANCE: csr_prdata = {1'b0, cfg_ff.resistance};
         emfo_pkg::REG_D_IND:      csr_prdata = {1'b0, cfg_ff.d_inductance};
         emfo_pkg::REG_Q_IND:      csr_prdata = {1'b0, cfg_ff.q_inductance};
         emfo_pkg::REG_FLUX:       csr_prdata = {1'b0, cfg_ff.flux_linkage};
         emfo_pkg::REG_SAMPLE:     csr_prdata = cfg_ff.sample_period;
         emfo_pkg::REG_LAMBDA:     csr_prdata = {1'b0, cfg_ff.lambda_gain};
         emfo_pkg::REG_BASE_BW:    csr_prdata = {1'b0, cfg_ff.base_bandwidth};
         emfo_pkg::REG_BW_SLOPE:   csr_prdata = {1'b0, cfg_ff.bandwidth_slope};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resistance      <= '0;
         cfg_ff.d_inductance    <= '0;
         cfg_ff.q_inductance    <= '0;
         cfg_ff.flux_linkage    <= '0;
         cfg_ff.sample_period   <= emfo_pkg::RST_SAMPLE;
         cfg_ff.lambda_gain     <= emfo_pkg::RST_LAMBDA;
         cfg_ff.base_bandwidth  <= emfo_pkg::RST_BASE_BW;
         cfg_ff.bandwidth_slope <= emfo_pkg::RST_SLOPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- hw/rtl/emfo_mul.sv -----
// Shared 33 by 33 bit signed multiplier with a registered product.
module emfo_mul (
   input  logic               clock,
   input  logic signed [32:0] mul_a,
   input  logic signed [32:0] mul_b,
   output logic signed [65:0] prod
);
   logic signed [65:0] prod_ff, prod_in;

   assign prod_in = 66'(mul_a) * 66'(mul_b);
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ----- hw/rtl/emfo_div.sv -----
// Unsigned restoring divider that produces one quotient bit per cycle.
module emfo_div (
   input  logic                  clock,
   input  logic                  reset,
   input  emfo_pkg::div_req_type div_req,
   output emfo_pkg::div_rsp_type div_rsp
);
   localparam int DW = emfo_pkg::DIV_DVD_W;
   localparam int SW = emfo_pkg::DIV_DSR_W;
   localparam int CW = emfo_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [SW:0]   shifted;
   logic [SW:0]   trial;

   assign shifted = {rem_ff, dvd_ff[DW-1]};
   assign trial = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = trial[SW-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[SW-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.quotient  = dvd_ff;
endmodule

// ----- hw/rtl/emfo_core.sv -----
// Sequencer and datapath of the observer around the shared multiplier and divider.
module emfo_core (
   input  logic              clock,
   input  logic              reset,
   input  emfo_pkg::cfg_type cfg,
   emfo_req_if.sink          req,
   emfo_rsp_if.source        rsp
);
   emfo_pkg::state_type state_ff, state_in;

   logic signed [31:0] ud_ff, ud_in, uq_ff, uq_in, id_ff, id_in, iq_ff, iq_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [31:0] ed_ff, ed_in, eq_ff, eq_in, num_ff, num_in, den_ff, den_in;
   logic signed [31:0] bw_ff, bw_in, wnew_ff, wnew_in;
   logic signed [35:0] x_ff, x_in;
   logic [62:0]        xp_ff, xp_in;
   logic [31:0]        e_ff, e_in;
   logic               eneg_ff, eneg_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        rm_ff, rm_in;
   logic signed [31:0] angle_ff, angle_in, speed_ff, speed_in;
   logic               rv_ff, rv_in;
   logic signed [31:0] ra_ff, ra_in, rs_ff, rs_in;
   logic               rf_ff, rf_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [31:0] q;
   emfo_pkg::div_req_type div_req;
   emfo_pkg::div_rsp_type div_rsp;

   logic signed [32:0] wabs;
   logic               wneg;
   logic signed [65:0] tmp66;
   logic signed [35:0] adv;
   logic signed [31:0] quot;
   logic signed [32:0] err;
   logic [96:0]        wide;
   logic [96:0]        wide_r;
   logic [48:0]        smag;
   logic signed [63:0] wsum;
   logic [31:0]        rmod;
   logic signed [35:0] xabs;
   logic [31:0]        numabs, denabs;
   logic [47:0]        qmag;
   logic               qneg;

   emfo_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .prod(prod));
   emfo_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign q = emfo_pkg::qround(prod);
   assign wneg = speed_ff[31];
   assign wabs = wneg ? -$signed({speed_ff[31], speed_ff}) : $signed({speed_ff[31], speed_ff});
   assign numabs = num_ff[31] ? 32'(-$signed({num_ff[31], num_ff})) : num_ff;
   assign denabs = den_ff[31] ? 32'(-$signed({den_ff[31], den_ff})) : den_ff;
   assign xabs = x_ff[35] ? -x_ff : x_ff;
   assign qmag = div_rsp.quotient;
   assign qneg = num_ff[31] ^ den_ff[31];

   assign req.ready = (state_ff == emfo_pkg::ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.angle_estimate = ra_ff;
   assign rsp.speed_estimate = rs_ff;
   assign rsp.divide_fault = rf_ff;

   // Multiplier operands per step.
   always_comb begin
      case (state_ff)
         emfo_pkg::ST_RID: begin
            mul_a = $signed({2'b0, cfg.resistance}); mul_b = $signed({id_ff[31], id_ff});
         end
         emfo_pkg::ST_WLQ: begin
            mul_a = $signed({speed_ff[31], speed_ff}); mul_b = $signed({2'b0, cfg.q_inductance});
         end
         emfo_pkg::ST_RIQ: begin
            mul_a = $signed({2'b0, cfg.resistance}); mul_b = $signed({iq_ff[31], iq_ff});
         end
         emfo_pkg::ST_P3: begin
            mul_a = $signed({b_ff[31], b_ff}); mul_b = $signed({iq_ff[31], iq_ff});
         end
         emfo_pkg::ST_ED: begin
            mul_a = $signed({speed_ff[31], speed_ff}); mul_b = $signed({2'b0, cfg.d_inductance});
         end
         emfo_pkg::ST_P5: begin
            mul_a = $signed({2'b0, cfg.d_inductance}) - $signed({2'b0, cfg.q_inductance});
            mul_b = $signed({id_ff[31], id_ff});
         end
         emfo_pkg::ST_P8: begin
            mul_a = $signed({b_ff[31], b_ff}); mul_b = $signed({id_ff[31], id_ff});
         end
         emfo_pkg::ST_EQ: begin
            mul_a = $signed({2'b0, cfg.lambda_gain}); mul_b = $signed({ed_ff[31], ed_ff});
         end
         emfo_pkg::ST_NUM: begin
            mul_a = $signed({2'b0, cfg.bandwidth_slope}); mul_b = wabs;
         end
         emfo_pkg::ST_BW: begin
            mul_a = $signed({1'b0, cfg.sample_period}); mul_b = wabs;
         end
         emfo_pkg::ST_ANG: begin
            mul_a = $signed({1'b0, cfg.sample_period}); mul_b = $signed({bw_ff[31], bw_ff});
         end
         emfo_pkg::ST_XPR: begin
            mul_a = $signed({1'b0, emfo_pkg::WRAP_RECIP}); mul_b = $signed({1'b0, xabs[31:0]});
         end
         emfo_pkg::ST_QE: begin
            mul_a = $signed({19'b0, prod[63:50]}); mul_b = $signed({1'b0, emfo_pkg::ANG_TWO_PI});
         end
         emfo_pkg::ST_ML: begin
            mul_a = $signed({1'b0, xp_ff[31:0]}); mul_b = $signed({1'b0, e_ff});
         end
         emfo_pkg::ST_MH: begin
            mul_a = $signed({2'b0, xp_ff[62:32]}); mul_b = $signed({1'b0, e_ff});
         end
         default: begin
            mul_a = '0; mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ud_in = ud_ff; uq_in = uq_ff; id_in = id_ff; iq_in = iq_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      ed_in = ed_ff; eq_in = eq_ff; num_in = num_ff; den_in = den_ff;
      bw_in = bw_ff; wnew_in = wnew_ff; x_in = x_ff; xp_in = xp_ff;
      e_in = e_ff; eneg_in = eneg_ff; acc_in = acc_ff; rm_in = rm_ff;
      angle_in = angle_ff; speed_in = speed_ff;
      rv_in = rv_ff && !rsp.ready;
      ra_in = ra_ff; rs_in = rs_ff; rf_in = rf_ff;
      div_req.start = 1'b0;
      div_req.dividend = '0;
      div_req.divisor = '0;
      tmp66 = '0; adv = '0; quot = '0; err = '0;
      wide = '0; wide_r = '0; smag = '0; wsum = '0; rmod = '0;

      case (state_ff)
         emfo_pkg::ST_IDLE: begin
            if (req.valid) begin
               ud_in = req.d_voltage; uq_in = req.q_voltage;
               id_in = req.d_current; iq_in = req.q_current;
               state_in = emfo_pkg::ST_RID;
            end
         end
         emfo_pkg::ST_RID: state_in = emfo_pkg::ST_WLQ;
         emfo_pkg::ST_WLQ: begin
            a_in = q;
            state_in = emfo_pkg::ST_RIQ;
         end
         emfo_pkg::ST_RIQ: begin
            b_in = q;
            state_in = emfo_pkg::ST_P3;
         end
         emfo_pkg::ST_P3: begin
            c_in = q;
            state_in = emfo_pkg::ST_ED;
         end
         emfo_pkg::ST_ED: begin
            ed_in = emfo_pkg::sat32(64'(ud_ff) - 64'(a_ff) + 64'(q));
            state_in = emfo_pkg::ST_P5;
         end
         emfo_pkg::ST_P5: begin
            b_in = q;
            state_in = emfo_pkg::ST_P8;
         end
         emfo_pkg::ST_P8: begin
            a_in = q;
            state_in = emfo_pkg::ST_EQ;
         end
         emfo_pkg::ST_EQ: begin
            eq_in = emfo_pkg::sat32(64'(uq_ff) - 64'(c_ff) - 64'(q));
            den_in = emfo_pkg::sat32($signed({33'b0, cfg.flux_linkage}) + 64'(a_ff));
            state_in = emfo_pkg::ST_NUM;
         end
         emfo_pkg::ST_NUM: begin
            // The d-EMF term is dropped at standstill, subtracted for positive and added for negative speed.
            if (speed_ff == 32'sd0) num_in = eq_ff;
            else if (wneg) num_in = emfo_pkg::sat32(64'(eq_ff) + 64'(q));
            else num_in = emfo_pkg::sat32(64'(eq_ff) - 64'(q));
            state_in = emfo_pkg::ST_BW;
         end
         emfo_pkg::ST_BW: begin
            bw_in = emfo_pkg::sat32($signed({33'b0, cfg.base_bandwidth}) + 64'(q));
            div_req.start = 1'b1;
            div_req.dividend = {numabs, 16'b0};
            div_req.divisor = denabs;
            state_in = emfo_pkg::ST_ANG;
         end
         emfo_pkg::ST_ANG: begin
            tmp66 = prod + 66'sd2147483648;
            adv = $signed({2'b0, tmp66[65:32]});
            if (wneg) adv = -adv;
            x_in = 36'(angle_ff) + adv + $signed({4'b0, emfo_pkg::ANG_PI});
            state_in = emfo_pkg::ST_XPR;
         end
         emfo_pkg::ST_XPR: begin
            xp_in = prod[62:0];
            state_in = emfo_pkg::ST_QE;
         end
         emfo_pkg::ST_QE: state_in = emfo_pkg::ST_RM;
         emfo_pkg::ST_RM: begin
            // The estimated count is at most one short, so one subtract finishes the wrap.
            rmod = xabs[31:0] - prod[31:0];
            if (rmod >= emfo_pkg::ANG_TWO_PI) rmod = rmod - emfo_pkg::ANG_TWO_PI;
            if (x_ff[35] && rmod != 32'd0) rmod = emfo_pkg::ANG_TWO_PI - rmod;
            rm_in = rmod;
            state_in = emfo_pkg::ST_WQ;
         end
         emfo_pkg::ST_WQ: begin
            if (!div_rsp.busy) begin
               if (den_ff == 32'sd0) quot = num_ff[31] ? 32'sh80000000 : 32'sh7fffffff;
               else if (!qneg) quot = (qmag > 48'd2147483647) ? 32'sh7fffffff : qmag[31:0];
               else if (qmag > 48'd2147483648) quot = 32'sh80000000;
               else quot = 32'(-$signed({1'b0, qmag[31:0]}));
               err = 33'(quot) - 33'(speed_ff);
               eneg_in = err[32];
               e_in = err[32] ? 32'(-err) : err[31:0];
               state_in = emfo_pkg::ST_ML;
            end
         end
         emfo_pkg::ST_ML: state_in = emfo_pkg::ST_MH;
         emfo_pkg::ST_MH: begin
            acc_in = prod[63:0];
            state_in = emfo_pkg::ST_SPD;
         end
         emfo_pkg::ST_SPD: begin
            wide = {33'b0, acc_ff} + {1'b0, prod[63:0], 32'b0};
            wide_r = wide + (97'd1 << 47);
            smag = wide_r[96:48];
            if (eneg_ff) wsum = 64'(speed_ff) - $signed({15'b0, smag});
            else wsum = 64'(speed_ff) + $signed({15'b0, smag});
            wnew_in = emfo_pkg::sat32(wsum);
            state_in = emfo_pkg::ST_WM;
         end
         emfo_pkg::ST_WM: begin
            if (!rv_ff || rsp.ready) begin
               angle_in = $signed(rm_ff - emfo_pkg::ANG_PI);
               speed_in = wnew_ff;
               ra_in = $signed(rm_ff - emfo_pkg::ANG_PI);
               rs_in = wnew_ff;
               rf_in = (den_ff == 32'sd0);
               rv_in = 1'b1;
               state_in = emfo_pkg::ST_IDLE;
            end
         end
         default: state_in = emfo_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emfo_pkg::ST_IDLE;
         angle_ff <= '0;
         speed_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         speed_ff <= speed_in;
         rv_ff    <= rv_in;
      end
      ud_ff <= ud_in; uq_ff <= uq_in; id_ff <= id_in; iq_ff <= iq_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      ed_ff <= ed_in; eq_ff <= eq_in; num_ff <= num_in; den_ff <= den_in;
      bw_ff <= bw_in; wnew_ff <= wnew_in; x_ff <= x_in; xp_ff <= xp_in;
      e_ff <= e_in; eneg_ff <= eneg_in; acc_ff <= acc_in; rm_ff <= rm_in;
      ra_ff <= ra_in; rs_ff <= rs_in; rf_ff <= rf_in;
   end
endmodule
